// ----- rtl/pft_pkg.sv -----
// Package for the polygon fan triangulator: sizing constants, payload structs,
// the front-to-back job format and the state encodings.
// No dependencies; every other file in rtl/ imports it.
package pft_pkg;

	localparam int INDEX_BITS  = 16;
	// Index bits actually kept (result fields are 16 bits wide)
	localparam int IDX_W       = (INDEX_BITS < 16) ? INDEX_BITS : 16;

	localparam int JOBQ_DEPTH  = 2;
	localparam int JOBQ_AW     = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
	localparam int JOBQ_CW     = $clog2(JOBQ_DEPTH + 1);

	localparam int RESQ_DEPTH  = 2;
	localparam int RESQ_AW     = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
	localparam int RESQ_CW     = $clog2(RESQ_DEPTH + 1);

	typedef logic signed [15:0] raw_t;    // raw file word
	typedef logic signed [16:0] coord_t;  // after x negation
	typedef logic signed [17:0] diff_t;   // edge vector component
	typedef logic signed [35:0] prod_t;   // diff x diff
	typedef logic signed [36:0] cross_t;  // cross product component
	typedef logic signed [53:0] term_t;   // cross x normal
	typedef logic signed [55:0] dot_t;    // dot product
	typedef logic [IDX_W-1:0]   idx_t;

	typedef struct packed {
		logic [15:0] vertex_index;
		raw_t        pos_x;
		raw_t        pos_y;
		raw_t        pos_z;
		raw_t        normal_x;
		raw_t        normal_y;
		raw_t        normal_z;
		logic        first_vertex;
		logic        last_vertex;
	} pft_in_t;

	typedef struct packed {
		logic [15:0] tri_a;
		logic [15:0] tri_b;
		logic [15:0] tri_c;
		logic        polygon_done;
	} pft_out_t;

	// Work item from front to back. For a fan triangle a/b/c are
	// anchor/previous/current and the winding is decided in the back;
	// otherwise a/b/c are already in output order.
	typedef struct packed {
		logic          fan;
		idx_t          a;
		idx_t          b;
		idx_t          c;
		logic          done;
		diff_t [2:0]   u;
		diff_t [2:0]   v;
		coord_t [2:0]  n;
	} job_t;

	typedef enum logic [1:0] {
		CC_NONE,
		CC_ANCHOR,
		CC_BOTH
	} corner_cnt_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIFF,
		BK_NMUL,
		BK_SUM
	} back_state_t;

endpackage

// ----- rtl/polygon_fan_triangulator.sv -----
// Polygon fan triangulator, one corner per push transaction and one fan
// triangle per pop transaction. A corner is taken whenever the two-entry
// job queue has room. Results whose order needs no test (one- and
// two-corner polygons) go straight to the result queue. A fan triangle
// steps through the back end states (edge products, cross difference,
// normal products, sum and sign), taking the next fan job as it writes
// the last result; on long polygons the winding sequence sets the rate. A
// two-entry result queue lets the back end finish while the consumer stalls.
// Depends on pft_pkg, pft_front, pft_queue and pft_back.
module polygon_fan_triangulator import pft_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  pft_in_t  vertex,
	output logic     empty,
	input  logic     pop,
	output pft_out_t triangle
);

	job_t front_job;
	logic front_push;
	logic jq_full;
	job_t head_job;
	logic head_valid;
	logic head_pop;

	pft_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.vertex   (vertex),
		.job      (front_job),
		.job_push (front_push),
		.job_full (jq_full)
	);

	pft_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_push),
		.wr_job (front_job),
		.full   (jq_full),
		.rd     (head_pop),
		.rd_job (head_job),
		.valid  (head_valid)
	);

	pft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.job_pop   (head_pop),
		.empty     (empty),
		.pop       (pop),
		.triangle  (triangle)
	);

endmodule

// ----- rtl/pft_front.sv -----
// Front end: takes polygon corners, tracks anchor/previous corner and emits
// one job per corner that yields a triangle. Depends on pft_pkg.
module pft_front import pft_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  pft_in_t vertex,
	output job_t    job,
	output logic    job_push,
	input  logic    job_full
);

	logic          accept;
	logic          start;
	idx_t          idx;
	coord_t [2:0]  pos;
	coord_t [2:0]  nrm;
	corner_cnt_t   cnt_d;

	corner_cnt_t   cnt_q;
	idx_t          anchor_idx_q;
	idx_t          prev_idx_q;
	coord_t [2:0]  anchor_pos_q;
	coord_t [2:0]  prev_pos_q;
	coord_t [2:0]  normal_q;

	assign full   = job_full;
	assign accept = push && !job_full;
	assign idx    = vertex.vertex_index[IDX_W-1:0];
	assign start  = vertex.first_vertex || (cnt_q == CC_NONE);

	// x axis is mirrored on entry
	always_comb begin
		pos[0] = -coord_t'(vertex.pos_x);
		pos[1] = coord_t'(vertex.pos_y);
		pos[2] = coord_t'(vertex.pos_z);
		nrm[0] = -coord_t'(vertex.normal_x);
		nrm[1] = coord_t'(vertex.normal_y);
		nrm[2] = coord_t'(vertex.normal_z);
	end

	always_comb begin
		job      = '0;
		job_push = 1'b0;
		cnt_d    = cnt_q;
		job.n    = normal_q;
		for (int k = 0; k < 3; k++) begin
			job.u[k] = diff_t'(prev_pos_q[k]) - diff_t'(anchor_pos_q[k]);
			job.v[k] = diff_t'(pos[k]) - diff_t'(anchor_pos_q[k]);
		end
		if (start) begin
			// single-corner polygon collapses to one point
			job.a    = idx;
			job.b    = idx;
			job.c    = idx;
			job.done = 1'b1;
			job_push = accept && vertex.last_vertex;
			cnt_d    = vertex.last_vertex ? CC_NONE : CC_ANCHOR;
		end else begin
			case (cnt_q)
				CC_ANCHOR: begin
					// two-corner polygon closes on the anchor
					job.a    = anchor_idx_q;
					job.b    = idx;
					job.c    = anchor_idx_q;
					job.done = 1'b1;
					job_push = accept && vertex.last_vertex;
					cnt_d    = vertex.last_vertex ? CC_NONE : CC_BOTH;
				end
				CC_BOTH: begin
					job.fan  = 1'b1;
					job.a    = anchor_idx_q;
					job.b    = prev_idx_q;
					job.c    = idx;
					job.done = vertex.last_vertex;
					job_push = accept;
					cnt_d    = vertex.last_vertex ? CC_NONE : CC_BOTH;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CC_NONE;
		end else if (accept) begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (start) begin
				anchor_idx_q <= idx;
				anchor_pos_q <= pos;
				normal_q     <= nrm;
			end else begin
				prev_idx_q <= idx;
				prev_pos_q <= pos;
			end
		end
	end

	a_fan_job: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cnt_q == CC_BOTH && !vertex.first_vertex |-> job_push && job.fan)
		else $error("third or later corner did not produce a fan job");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept && vertex.last_vertex |=> cnt_q == CC_NONE)
		else $error("polygon still open after its last corner");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into a full queue");

endmodule

// ----- rtl/pft_queue.sv -----
// Short job queue between front and back so that each side stalls on its own.
// Depends on pft_pkg (job_t, JOBQ_* sizing).
module pft_queue import pft_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	output logic full,
	input  logic rd,
	output job_t rd_job,
	output logic valid
);

	job_t                 mem_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0]   wr_ptr_q;
	logic [JOBQ_AW-1:0]   rd_ptr_q;
	logic [JOBQ_CW-1:0]   cnt_q;

	assign full   = (cnt_q == JOBQ_CW'(JOBQ_DEPTH));
	assign valid  = (cnt_q != '0);
	assign rd_job = mem_q[rd_ptr_q];

	function automatic logic [JOBQ_AW-1:0] next_ptr(input logic [JOBQ_AW-1:0] p);
		return (p == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (rd)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= wr_job;
	end

	a_rd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> valid)
		else $error("job queue read while empty");

	a_wr_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("job queue written while full");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd && !full |=> valid)
		else $error("job queue lost a transaction");

endmodule

// ----- rtl/pft_back.sv -----
// Back end: winding test for fan triangles (cross product, then dot with the
// face normal, one multiply step per cycle) and the result queue.
// Depends on pft_pkg.
module pft_back import pft_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	input  job_t     job,
	output logic     job_pop,
	output logic     empty,
	input  logic     pop,
	output pft_out_t triangle
);

	back_state_t          state_q;
	back_state_t          state_d;
	logic                 load;
	logic                 res_wr;
	logic                 res_space;
	logic                 res_rd;
	pft_out_t             res_d;
	dot_t                 dot;
	logic                 front_facing;

	job_t                 job_q;
	prod_t  [2:0]         pa_q;
	prod_t  [2:0]         pb_q;
	cross_t [2:0]         c_q;
	term_t  [2:0]         t_q;

	pft_out_t             res_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0]   res_wr_ptr_q;
	logic [RESQ_AW-1:0]   res_rd_ptr_q;
	logic [RESQ_CW-1:0]   res_cnt_q;

	assign res_space    = (res_cnt_q != RESQ_CW'(RESQ_DEPTH));
	assign empty        = (res_cnt_q == '0);
	assign res_rd       = pop && !empty;
	assign triangle     = res_q[res_rd_ptr_q];
	assign dot          = dot_t'(t_q[0]) + dot_t'(t_q[1]) + dot_t'(t_q[2]);
	assign front_facing = !dot[$bits(dot_t)-1] && (dot != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (job_valid && job.fan) state_d = BK_MUL;
			BK_MUL:  state_d = BK_DIFF;
			BK_DIFF: state_d = BK_NMUL;
			BK_NMUL: state_d = BK_SUM;
			BK_SUM: begin
				if (res_space)
					state_d = (job_valid && job.fan) ? BK_MUL : BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop = 1'b0;
		load    = 1'b0;
		res_wr  = 1'b0;
		res_d   = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					if (job.fan) begin
						job_pop = 1'b1;
						load    = 1'b1;
					end else if (res_space) begin
						// order already fixed in the front
						job_pop            = 1'b1;
						res_wr             = 1'b1;
						res_d.tri_a        = 16'(job.a);
						res_d.tri_b        = 16'(job.b);
						res_d.tri_c        = 16'(job.c);
						res_d.polygon_done = job.done;
					end
				end
			end
			BK_SUM: begin
				if (res_space) begin
					res_wr             = 1'b1;
					res_d.tri_a        = 16'(job_q.a);
					res_d.tri_b        = front_facing ? 16'(job_q.b) : 16'(job_q.c);
					res_d.tri_c        = front_facing ? 16'(job_q.c) : 16'(job_q.b);
					res_d.polygon_done = job_q.done;
					// overlap: pick up the next fan job right away
					if (job_valid && job.fan) begin
						job_pop = 1'b1;
						load    = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// cross(u, v) then dot with the normal, products and cross difference registered between multiplies
	always_ff @(posedge clk) begin
		if (load)
			job_q <= job;
		if (state_q == BK_MUL) begin
			for (int k = 0; k < 3; k++) begin
				pa_q[k] <= job_q.u[(k + 1) % 3] * job_q.v[(k + 2) % 3];
				pb_q[k] <= job_q.u[(k + 2) % 3] * job_q.v[(k + 1) % 3];
			end
		end
		if (state_q == BK_DIFF) begin
			for (int k = 0; k < 3; k++)
				c_q[k] <= cross_t'(pa_q[k]) - cross_t'(pb_q[k]);
		end
		if (state_q == BK_NMUL) begin
			for (int k = 0; k < 3; k++)
				t_q[k] <= c_q[k] * job_q.n[k];
		end
	end

	function automatic logic [RESQ_AW-1:0] next_ptr(input logic [RESQ_AW-1:0] p);
		return (p == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_ptr_q <= '0;
			res_rd_ptr_q <= '0;
			res_cnt_q    <= '0;
		end else begin
			if (res_wr)
				res_wr_ptr_q <= next_ptr(res_wr_ptr_q);
			if (res_rd)
				res_rd_ptr_q <= next_ptr(res_rd_ptr_q);
			if (res_wr && !res_rd)
				res_cnt_q <= res_cnt_q + 1'b1;
			else if (res_rd && !res_wr)
				res_cnt_q <= res_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr)
			res_q[res_wr_ptr_q] <= res_d;
	end

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_MUL |=> state_q == BK_DIFF)
		else $error("winding sequence skipped a step");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SUM && !res_space |=> state_q == BK_SUM)
		else $error("winding result dropped while result queue full");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> res_space)
		else $error("result queue written while full");

	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job taken from an empty queue");

endmodule

// ----- tb/polygon_fan_triangulator_tb.sv -----
// Self-checking testbench for polygon_fan_triangulator: directed corner cases, then random
// polygons and noise, with bursty input, patterned output stalls and a bit-exact winding predictor.
// Depends on pft_pkg and the polygon_fan_triangulator RTL.
module polygon_fan_triangulator_tb;
	import pft_pkg::*;

	localparam int IDLE_LIMIT     = 3000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int RANDOM_CORNERS = 400;
	localparam int HOLD_CYCLES    = 80;

	typedef struct {
		pft_in_t corner;
		bit      drain;   // wait for every pending triangle before offering this one
	} corner_job_t;

	typedef enum int {CM_FULL, CM_SMALL, CM_EXTREME, CM_MEDIUM} coord_mode_t;
	typedef enum int {RX_STREAM, RX_HALF, RX_SPARSE, RX_MASK} rx_mode_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     full;
	pft_in_t  vertex = '0;
	logic     empty;
	logic     pop = 1'b0;
	pft_out_t triangle;

	polygon_fan_triangulator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.vertex   (vertex),
		.empty    (empty),
		.pop      (pop),
		.triangle (triangle)
	);

	corner_job_t corner_q[$];
	pft_out_t    tri_expect[$];
	int          corners_sent = 0;
	int          corners_taken = 0;
	int          corners_total = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;

	// fan state mirrored from the block
	idx_t        anchor_idx = '0;
	idx_t        prev_idx = '0;
	coord_t      anchor_pos[3] = '{default: '0};
	coord_t      prev_pos[3] = '{default: '0};
	coord_t      face_n[3] = '{default: '0};
	corner_cnt_t corners = CC_NONE;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic coord_t to_coord(raw_t r, bit flip);
		coord_t c;
		c = coord_t'(r);
		return flip ? -c : c;
	endfunction

	function automatic void fan_predict(pft_in_t c);
		idx_t     idx;
		coord_t   p[3];
		longint   u[3], v[3], cr[3], dot;
		pft_out_t t;
		idx  = c.vertex_index[IDX_W-1:0];
		p[0] = to_coord(c.pos_x, 1'b1);
		p[1] = to_coord(c.pos_y, 1'b0);
		p[2] = to_coord(c.pos_z, 1'b0);
		if (c.first_vertex || corners == CC_NONE) begin
			anchor_idx = idx;
			anchor_pos = p;
			face_n[0]  = to_coord(c.normal_x, 1'b1);
			face_n[1]  = to_coord(c.normal_y, 1'b0);
			face_n[2]  = to_coord(c.normal_z, 1'b0);
			if (c.last_vertex) begin
				corners = CC_NONE;
				tri_expect.push_back('{16'(idx), 16'(idx), 16'(idx), 1'b1});
			end else begin
				corners = CC_ANCHOR;
			end
		end else if (corners == CC_ANCHOR) begin
			prev_idx = idx;
			prev_pos = p;
			if (c.last_vertex) begin
				corners = CC_NONE;
				tri_expect.push_back('{16'(anchor_idx), 16'(idx), 16'(anchor_idx), 1'b1});
			end else begin
				corners = CC_BOTH;
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				u[k] = longint'(prev_pos[k]) - longint'(anchor_pos[k]);
				v[k] = longint'(p[k]) - longint'(anchor_pos[k]);
			end
			cr[0] = u[1] * v[2] - u[2] * v[1];
			cr[1] = u[2] * v[0] - u[0] * v[2];
			cr[2] = u[0] * v[1] - u[1] * v[0];
			dot = cr[0] * longint'(face_n[0]) + cr[1] * longint'(face_n[1])
				+ cr[2] * longint'(face_n[2]);
			// zero or negative winding takes the reversed order
			if (dot > 0)
				t = '{16'(anchor_idx), 16'(prev_idx), 16'(idx), c.last_vertex};
			else
				t = '{16'(anchor_idx), 16'(idx), 16'(prev_idx), c.last_vertex};
			tri_expect.push_back(t);
			prev_idx = idx;
			prev_pos = p;
			corners  = c.last_vertex ? CC_NONE : CC_BOTH;
		end
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic queue_corner(logic [15:0] idx, raw_t x, raw_t y, raw_t z,
			raw_t nx, raw_t ny, raw_t nz, bit first, bit last, bit drain = 1'b0);
		corner_job_t j;
		j.corner = '{idx, x, y, z, nx, ny, nz, first, last};
		j.drain  = drain;
		corner_q.push_back(j);
		corners_total++;
	endtask

	function automatic raw_t pick_coord(coord_mode_t mode);
		case (mode)
			CM_FULL:   return raw_t'($urandom);
			CM_SMALL:  return raw_t'(int'($urandom_range(0, 128)) - 64);
			CM_MEDIUM: return raw_t'(int'($urandom_range(0, 4000)) - 2000);
			default: begin
				case ($urandom_range(0, 3))
					0:       return raw_t'(-32768);
					1:       return raw_t'(32767);
					2:       return raw_t'(0);
					default: return raw_t'(-1);
				endcase
			end
		endcase
	endfunction

	// receiver stall state, shared with the sender
	int       rx_hold_left = 0;
	int       rx_holds = 0;
	int       rx_phase = 0;
	rx_mode_t rx_mode = RX_STREAM;
	logic [7:0] rx_mask = 8'hff;

	// sender: bursts of random length separated by random gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin : sender
		logic        nxt_push;
		corner_job_t j;
		if (arst_n) begin
			nxt_push = push && (corners_taken != corners_sent);
			if (!nxt_push) begin
				if (gap_left > 0 && rx_hold_left == 0) begin
					gap_left--;
				end else if (corner_q.size() > 0
						&& !(corner_q[0].drain && tri_expect.size() > 0)) begin
					j = corner_q.pop_front();
					vertex <= j.corner;
					nxt_push = 1'b1;
					corners_sent++;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end
			end
			push <= nxt_push;
		end
	end

	// receiver: stall pattern is redrawn whenever its phase counter runs out; two long hold-offs fill the block
	always @(negedge clk) begin : receiver
		logic nxt_pop;
		if (arst_n) begin
			if (rx_phase == 0) begin
				rx_mode  = rx_mode_t'($urandom_range(0, 3));
				rx_mask  = 8'($urandom);
				rx_phase = $urandom_range(16, 64);
			end else begin
				rx_phase--;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				nxt_pop = 1'b0;
			end else if ((rx_holds == 0 && corners_taken >= 40)
					|| (rx_holds == 1 && corners_taken >= 260)) begin
				rx_holds++;
				rx_hold_left = HOLD_CYCLES;
				nxt_pop = 1'b0;
			end else begin
				case (rx_mode)
					RX_STREAM: nxt_pop = 1'b1;
					RX_HALF:   nxt_pop = 1'($urandom_range(0, 1));
					RX_SPARSE: nxt_pop = ($urandom_range(0, 3) == 0);
					default: begin
						nxt_pop = rx_mask[0];
						rx_mask = {rx_mask[0], rx_mask[7:1]};
					end
				endcase
			end
			pop <= nxt_pop;
		end
	end

	// monitor: predicts on each input transaction, checks each output transaction
	always @(posedge clk) begin : monitor
		pft_out_t want;
		bit       moved;
		if (arst_n) begin
			moved = 1'b0;
			if (push && !full) begin
				fan_predict(vertex);
				corners_taken++;
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				if (tri_expect.size() == 0) begin
					$error("unexpected triangle %h %h %h done=%b", triangle.tri_a,
						triangle.tri_b, triangle.tri_c, triangle.polygon_done);
					mismatches++;
				end else begin
					want = tri_expect.pop_front();
					check_field("tri_a", want.tri_a, triangle.tri_a);
					check_field("tri_b", want.tri_b, triangle.tri_b);
					check_field("tri_c", want.tri_c, triangle.tri_c);
					check_field("polygon_done", 16'(want.polygon_done),
						16'(triangle.polygon_done));
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int          len;
		bit          close;
		bit          drain_done;
		coord_mode_t cmode;
		raw_t        nx, ny, nz;
		logic [15:0] base;

		// no polygon open: a plain corner starts one; winding comes out reversed
		queue_corner(16'd5, 0, 0, 0, 0, 0, 1, 1'b0, 1'b0);
		queue_corner(16'd6, 1, 0, 0, 0, 0, 0, 1'b0, 1'b0);
		queue_corner(16'd7, 0, 1, 0, 0, 0, 0, 1'b0, 1'b1);
		// same shape with the normal flipped takes the forward order
		queue_corner(16'd8, 0, 0, 0, 0, 0, -1, 1'b1, 1'b0);
		queue_corner(16'd9, 1, 0, 0, 7, 7, 7, 1'b0, 1'b0);
		queue_corner(16'd10, 0, 1, 0, 0, 0, 0, 1'b0, 1'b1);
		// single corner polygon, after a full drain
		queue_corner(16'hffff, 32767, -32768, 1, -1, 2, 3, 1'b1, 1'b1, 1'b1);
		// two corner polygon
		queue_corner(16'h0000, 3, 4, 5, 1, 1, 1, 1'b1, 1'b0);
		queue_corner(16'h1234, -3, -4, -5, 0, 0, 0, 1'b0, 1'b1);
		// extreme coordinates and normal
		queue_corner(16'd100, -32768, -32768, -32768, -32768, 32767, -32768, 1'b1, 1'b0);
		queue_corner(16'd101, 32767, 32767, -32768, 0, 0, 0, 1'b0, 1'b0);
		queue_corner(16'd102, 32767, -32768, 32767, 0, 0, 0, 1'b0, 1'b0);
		queue_corner(16'd103, -32768, 32767, 32767, 0, 0, 0, 1'b0, 1'b1);
		// collinear corners give a zero dot product
		queue_corner(16'd200, 0, 0, 0, 1, 1, 1, 1'b1, 1'b0);
		queue_corner(16'd201, 2, 2, 2, 0, 0, 0, 1'b0, 1'b0);
		queue_corner(16'd202, 4, 4, 4, 0, 0, 0, 1'b0, 1'b1);
		// open polygon dropped by a new first corner
		queue_corner(16'd300, 0, 0, 0, 0, 0, 1, 1'b1, 1'b0);
		queue_corner(16'd301, 5, 0, 0, 0, 0, 0, 1'b0, 1'b0);
		queue_corner(16'd302, 0, 5, 0, 0, 0, 0, 1'b0, 1'b0);
		queue_corner(16'd310, 0, 0, 0, 32767, 32767, 32767, 1'b1, 1'b0);
		queue_corner(16'd311, -9, 3, 2, 0, 0, 0, 1'b0, 1'b0);
		queue_corner(16'd312, 4, -8, 6, 0, 0, 0, 1'b0, 1'b1);

		drain_done = 1'b0;
		while (corners_total < RANDOM_CORNERS + 22) begin
			if ($urandom_range(0, 99) < 12) begin
				queue_corner(16'($urandom), raw_t'($urandom), raw_t'($urandom),
					raw_t'($urandom), raw_t'($urandom), raw_t'($urandom),
					raw_t'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
				close = ($urandom_range(0, 9) != 0);
				cmode = coord_mode_t'($urandom_range(0, 3));
				nx    = pick_coord(cmode);
				ny    = pick_coord(cmode);
				nz    = pick_coord(cmode);
				base  = 16'($urandom);
				for (int k = 0; k < len; k++) begin
					if (k == 0)
						queue_corner(base, pick_coord(cmode), pick_coord(cmode),
							pick_coord(cmode), nx, ny, nz, 1'b1, close && len == 1,
							!drain_done && corners_total >= 200);
					else
						queue_corner(($urandom_range(0, 1) ? base + 16'(k) : 16'($urandom)),
							pick_coord(cmode), pick_coord(cmode), pick_coord(cmode),
							raw_t'($urandom), raw_t'($urandom), raw_t'($urandom),
							1'b0, close && k == len - 1);
					if (!drain_done && corners_total > 200)
						drain_done = 1'b1;
				end
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (corners_taken == corners_total);
		wait (tri_expect.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tri_expect.size() != 0) begin
			$error("%0d triangles never arrived", tri_expect.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
